[sv/ldrc_pkg.sv]
// Package for the label dense rank compactor.
// Holds widths, command codes, sequencer states and the result type.
// No dependencies.
package ldrc_pkg;

  // Label space and presence map organization
  localparam int unsigned LabelBits = 10;
  localparam int unsigned WordBits  = 5;
  localparam int unsigned WordW     = 1 << WordBits;
  localparam int unsigned RowBits   = LabelBits - WordBits;
  localparam int unsigned Rows      = 1 << RowBits;
  localparam int unsigned Labels    = 1 << LabelBits;

  // Field widths
  localparam int unsigned RankBits  = 10;
  localparam int unsigned CountBits = 11;
  localparam int unsigned InDataW   = 16;
  localparam int unsigned InUserW   = 2;
  localparam int unsigned OutDataW  = 24;
  localparam int unsigned OutUserW  = 1;

  typedef enum logic [1:0] {
    CMD_MARK     = 2'd0,
    CMD_FINALIZE = 2'd1,
    CMD_REMAP    = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIN_RD,
    ST_FIN_LOAD,
    ST_FIN_BIT,
    ST_FIN_DONE
  } fsm_e;

  typedef struct packed {
    logic                 unknown;
    logic [CountBits-1:0] count;
    logic [RankBits-1:0]  rank;
  } result_t;

endpackage

[sv/label_dense_rank_compactor.sv]
// Top level of the label dense rank compactor: presence map, rank table,
// finalize sequencer. Depends on ldrc_pkg and ldrc_out_fifo.
//
// Usage: commands arrive on the s_axis stream (tuser = command, tdata = label)
// and results leave on the m_axis stream (tdata = rank and count, tuser =
// unknown flag). Mark and clear give no result; finalize and remap give one.
// Mark, clear and remap are taken one per cycle while no finalize walk runs
// and the result queue has room. A remap result passes the synchronous map
// and rank-table reads, then the result queue register, before it shows on
// m_axis. Back-to-back marks to the same map word are handled by forwarding
// the last written word. Finalize walks the presence map word by word: it
// reads and loads each word, then checks one label per cycle, writing one
// rank-table entry per present label through the single rank-table write
// port; its result is queued in the cycle after the last label. No command
// is taken during the walk. Reset clears the per-word valid bits of the
// presence map at once, so the map reads as empty without a clearing pass;
// clear does the same. The rank table is not reset. A two-entry result queue
// lets commands keep flowing while a result waits; when the receiver stalls,
// s_axis_tready_o drops once two results are queued or in flight.
module label_dense_rank_compactor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [9:0] label, upper bits zero
  input  logic [ldrc_pkg::InDataW-1:0]  s_axis_tdata_i,
  // [1:0] cmd
  input  logic [ldrc_pkg::InUserW-1:0]  s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [9:0] rank, [20:10] distinct_count, upper bits zero
  output logic [ldrc_pkg::OutDataW-1:0] m_axis_tdata_o,
  // [0] unknown_label
  output logic [ldrc_pkg::OutUserW-1:0] m_axis_tuser_o
);

  // Input decode
  logic                           in_accept;
  ldrc_pkg::cmd_e                 in_cmd;
  logic [ldrc_pkg::LabelBits-1:0] in_label;
  logic [ldrc_pkg::RowBits-1:0]   in_row;

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign in_cmd    = ldrc_pkg::cmd_e'(s_axis_tuser_i);
  assign in_label  = s_axis_tdata_i[ldrc_pkg::LabelBits-1:0];
  assign in_row    = in_label[ldrc_pkg::LabelBits-1:ldrc_pkg::WordBits];

  // Memories
  logic [ldrc_pkg::WordW-1:0]    map_mem  [ldrc_pkg::Rows];
  logic [ldrc_pkg::RankBits-1:0] rank_mem [ldrc_pkg::Labels];
  logic [ldrc_pkg::WordW-1:0]    rd_word_q;
  logic [ldrc_pkg::RankBits-1:0] rank_rd_q;
  logic [ldrc_pkg::Rows-1:0]     row_valid_q, row_valid_d;

  // Lookup stage
  logic                           s1_valid_q;
  ldrc_pkg::cmd_e                 s1_cmd_q;
  logic [ldrc_pkg::LabelBits-1:0] s1_label_q;
  logic [ldrc_pkg::RowBits-1:0]   s1_row;
  logic [ldrc_pkg::WordBits-1:0]  s1_bit;
  logic                           s1_mark, s1_res;

  // Forwarding of the last map write
  logic                           fwd_valid_q;
  logic [ldrc_pkg::RowBits-1:0]   fwd_row_q;
  logic [ldrc_pkg::WordW-1:0]     fwd_word_q;
  logic [ldrc_pkg::WordW-1:0]     eff_word, mark_word;
  logic                           fwd_hit, present;

  // Finalize sequencer
  ldrc_pkg::fsm_e                 state_q, state_d;
  logic [ldrc_pkg::RowBits-1:0]   row_q, row_d;
  logic [ldrc_pkg::WordBits-1:0]  bit_q, bit_d;
  logic [ldrc_pkg::WordW-1:0]     word_q, word_d;
  logic [ldrc_pkg::CountBits-1:0] cnt_q, cnt_d;
  logic                           rank_we, fin_push;
  logic [ldrc_pkg::CountBits-1:0] total_q;
  logic [ldrc_pkg::RowBits-1:0]   map_rd_row;

  // Result queue
  logic              q_push, q_pop, q_valid;
  ldrc_pkg::result_t q_push_data, q_data;
  logic [1:0]        q_occ, load;

  // Stage decode
  assign s1_row  = s1_label_q[ldrc_pkg::LabelBits-1:ldrc_pkg::WordBits];
  assign s1_bit  = s1_label_q[ldrc_pkg::WordBits-1:0];
  assign s1_mark = s1_valid_q && (s1_cmd_q == ldrc_pkg::CMD_MARK);
  assign s1_res  = s1_valid_q && (s1_cmd_q == ldrc_pkg::CMD_REMAP);

  // Effective map word: forwarded when the previous item wrote this word
  assign fwd_hit   = fwd_valid_q && (fwd_row_q == s1_row);
  assign eff_word  = row_valid_q[s1_row] ? (fwd_hit ? fwd_word_q : rd_word_q) : '0;
  assign mark_word = eff_word | (ldrc_pkg::WordW'(1) << s1_bit);
  assign present   = eff_word[s1_bit];

  // Accept when idle and the queue can hold one more result
  assign q_pop = q_valid && m_axis_tready_i;
  assign load  = q_occ + 2'(s1_res);
  assign s_axis_tready_o = (state_q == ldrc_pkg::ST_IDLE) &&
                           ((load < 2'd2) || ((load == 2'd2) && q_pop));

  // Map read port is shared between lookups and the walk
  assign map_rd_row = (state_q == ldrc_pkg::ST_FIN_RD) ? row_q : in_row;

  // Memory ports
  always_ff @(posedge clk_i) begin
    rd_word_q <= map_mem[map_rd_row];
    if (s1_mark) begin
      map_mem[s1_row] <= mark_word;
    end
    rank_rd_q <= rank_mem[in_label];
    if (rank_we) begin
      rank_mem[{row_q, bit_q}] <= cnt_q[ldrc_pkg::RankBits-1:0];
    end
  end

  // Word valid bits: clear wins over a mark written at the same edge
  always_comb begin
    row_valid_d = row_valid_q;
    if (s1_mark) row_valid_d[s1_row] = 1'b1;
    if (in_accept && (in_cmd == ldrc_pkg::CMD_CLEAR)) row_valid_d = '0;
  end

  // Stage and forwarding control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      row_valid_q <= row_valid_d;
      s1_valid_q  <= in_accept &&
                     ((in_cmd == ldrc_pkg::CMD_MARK) || (in_cmd == ldrc_pkg::CMD_REMAP));
      fwd_valid_q <= s1_mark;
      if (in_accept && (in_cmd == ldrc_pkg::CMD_CLEAR)) begin
        total_q <= '0;
      end else if (fin_push) begin
        total_q <= cnt_q;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    s1_cmd_q   <= in_cmd;
    s1_label_q <= in_label;
    fwd_row_q  <= s1_row;
    fwd_word_q <= mark_word;
  end

  // Finalize walk: next state and outputs
  always_comb begin
    state_d  = state_q;
    row_d    = row_q;
    bit_d    = bit_q;
    word_d   = word_q;
    cnt_d    = cnt_q;
    rank_we  = 1'b0;
    fin_push = 1'b0;
    case (state_q)
      ldrc_pkg::ST_IDLE: begin
        if (in_accept && (in_cmd == ldrc_pkg::CMD_FINALIZE)) begin
          state_d = ldrc_pkg::ST_FIN_RD;
          row_d   = '0;
          cnt_d   = '0;
        end
      end
      ldrc_pkg::ST_FIN_RD: begin
        state_d = ldrc_pkg::ST_FIN_LOAD;
      end
      ldrc_pkg::ST_FIN_LOAD: begin
        word_d  = row_valid_q[row_q] ? rd_word_q : '0;
        bit_d   = '0;
        state_d = ldrc_pkg::ST_FIN_BIT;
      end
      ldrc_pkg::ST_FIN_BIT: begin
        if (word_q[bit_q]) begin
          rank_we = 1'b1;
          cnt_d   = cnt_q + ldrc_pkg::CountBits'(1);
        end
        bit_d = bit_q + ldrc_pkg::WordBits'(1);
        if (&bit_q) begin
          if (&row_q) begin
            state_d = ldrc_pkg::ST_FIN_DONE;
          end else begin
            row_d   = row_q + ldrc_pkg::RowBits'(1);
            state_d = ldrc_pkg::ST_FIN_RD;
          end
        end
      end
      ldrc_pkg::ST_FIN_DONE: begin
        fin_push = 1'b1;
        state_d  = ldrc_pkg::ST_IDLE;
      end
      default: begin
        state_d = ldrc_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ldrc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Walk datapath
  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    bit_q  <= bit_d;
    word_q <= word_d;
    cnt_q  <= cnt_d;
  end

  // Result selection: remap from the lookup stage, count from the walk
  always_comb begin
    q_push = s1_res || fin_push;
    if (fin_push) begin
      q_push_data.rank    = '0;
      q_push_data.count   = cnt_q;
      q_push_data.unknown = 1'b0;
    end else begin
      q_push_data.rank    = present ? rank_rd_q : '0;
      q_push_data.count   = total_q;
      q_push_data.unknown = !present;
    end
  end

  ldrc_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .occ_o       (q_occ)
  );

  // Output packing
  assign m_axis_tvalid_o = q_valid;
  assign m_axis_tdata_o  = {
    (ldrc_pkg::OutDataW - ldrc_pkg::RankBits - ldrc_pkg::CountBits)'(0),
    q_data.count, q_data.rank};
  assign m_axis_tuser_o  = q_data.unknown;

  // Results queued or in flight never exceed the queue depth
  a_load_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load != 2'd3)
    else $error("result queue overcommitted");

  // No lookup is in flight while the map is walked
  a_walk_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ldrc_pkg::ST_IDLE) |-> !s1_valid_q)
    else $error("lookup overlaps finalize walk");

  // The end of a walk always leaves a result on the output
  a_fin_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ldrc_pkg::ST_FIN_DONE) |=> m_axis_tvalid_o)
    else $error("finalize result missing");

endmodule

[sv/ldrc_out_fifo.sv]
// Two-entry result queue between the compactor core and the output stream.
// Depends on ldrc_pkg for the result type.
module ldrc_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ldrc_pkg::result_t push_data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output ldrc_pkg::result_t data_o,
  output logic [1:0]       occ_o
);

  ldrc_pkg::result_t mem_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        occ_q;

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      occ_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      occ_q <= occ_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign valid_o = (occ_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign occ_o   = occ_q;

endmodule
